// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ngh_pkg.sv =====
// Types and constants for the nearest-goal heading cost block.
// No dependencies; used by the top module, its checker and the testbench.
`timescale 1ns / 1ps
package ngh_pkg;

	localparam int MAX_GOALS_DEF = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_CUR_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUR_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORI_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd4;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_SCORE = 1'b1;

	localparam logic [1:0] STAT_SCORED = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_NO_GOAL = 2'd2;

	localparam logic [15:0] ORI_GAIN_RST = 16'd256;
	localparam logic [15:0] VEL_GAIN_RST = 16'd256;
	localparam logic [22:0] SPEED_LIMIT_RST = 23'd65536;

	localparam logic [30:0] PI_Q29 = 31'd1686629713;
	localparam logic [15:0] ANGLE_PI_4 = 16'd8192;
	localparam logic [31:0] BIG_COST = 32'd65536000;
	localparam logic [63:0] TH_ROUND = 64'h0000_0008_0000_0000;
	localparam logic [39:0] VC_ROUND = 40'd128;

	typedef struct packed {
		logic               func;
		logic               first;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic signed [15:0] goal_yaw;
		logic               traj_empty;
		logic signed [15:0] end_yaw;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] cost;
	} rsp_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] yaw;
	} goal_ent_t;

endpackage

// ===== rtl/core/nearest_goal_heading_cost_top.sv =====
// Nearest-goal heading cost: goal table in RAM, pipelined nearest scan, speed unit.
// Load: accepted while idle, no result. Empty trajectory or empty table: result in the next cycle.
// Score: the result follows the one-read-per-cycle table scan and the 32-step square root,
// which run side by side, and then the heading and speed cost arithmetic.
// One request at a time. Reset clears control/config registers and goal count; table contents stay undefined.
`timescale 1ns / 1ps
module nearest_goal_heading_cost_top #(
	parameter int MAX_GOALS = ngh_pkg::MAX_GOALS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  ngh_pkg::req_t                  req,
	output logic                           done,
	output ngh_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ngh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import ngh_pkg::*;

	localparam int AW = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;
	localparam int CW = $clog2(MAX_GOALS + 1);
	localparam int EW = $bits(goal_ent_t);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_ANG, S_MUL1, S_MUL2, S_WAIT, S_VMUL, S_FIN
	} state_t;

	state_t state_q;
	logic done_q;
	rsp_t rsp_q;

	logic signed [31:0] cur_x_q, cur_y_q;
	logic [15:0] ori_gain_q, vel_gain_q;
	logic [22:0] limit_q;
	logic [CW-1:0] count_q, scan_q, cnt_eff;
	logic [15:0] end_yaw_q, best_yaw_q;
	logic [64:0] best_q;

	logic accept, room, we, issue, spd_start, spd_done;
	logic [31:0] speed, vx_mag, vy_mag;
	goal_ent_t wdata, rdata;

	logic v_s1, v_s2, v_s3, first_s1, first_s2, first_s3;
	logic [31:0] mx_s2, my_s2;
	logic [15:0] yaw_s2, yaw_s3;
	logic [63:0] sx_s3, sy_s3;
	logic [32:0] dx, dy;
	logic [64:0] sq_dist;

	logic [15:0] diff, ang_c, ang_q;
	logic big_q;
	logic [31:0] p1_q;
	logic [62:0] p2_q;
	logic [22:0] sf_q;
	logic [38:0] vp_q;
	logic [63:0] th_sum;
	logic [39:0] vc_sum;
	logic [31:0] vcost;
	logic [32:0] total;

	assign accept = start & ~busy;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign rsp = rsp_q;

	assign cnt_eff = req.first ? '0 : count_q;
	assign room = (cnt_eff < CW'(MAX_GOALS));
	assign we = accept && (req.func == FUNC_LOAD) && room;
	assign wdata = '{x: req.goal_x, y: req.goal_y, yaw: req.goal_yaw};
	assign issue = (state_q == S_SCAN) && (scan_q < count_q);

	ngh_ram #(.W(EW), .D(MAX_GOALS), .AW(AW)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_eff[AW-1:0]),
		.wdata (wdata),
		.raddr (scan_q[AW-1:0]),
		.rdata (rdata)
	);

	assign vx_mag = req.vel_x[31] ? (~req.vel_x + 32'd1) : req.vel_x;
	assign vy_mag = req.vel_y[31] ? (~req.vel_y + 32'd1) : req.vel_y;
	assign spd_start = accept && (req.func == FUNC_SCORE) && !req.traj_empty
		&& (count_q != '0);

	ngh_speed u_speed (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (spd_start),
		.vx     (vx_mag),
		.vy     (vy_mag),
		.done   (spd_done),
		.speed  (speed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			ori_gain_q <= ORI_GAIN_RST;
			vel_gain_q <= VEL_GAIN_RST;
			limit_q <= SPEED_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CUR_X: cur_x_q <= cfg_data;
				CFG_CUR_Y: cur_y_q <= cfg_data;
				CFG_ORI_GAIN: ori_gain_q <= cfg_data[15:0];
				CFG_VEL_GAIN: vel_gain_q <= cfg_data[15:0];
				CFG_SPEED_LIMIT: limit_q <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	assign dx = {rdata.x[31], rdata.x} - {cur_x_q[31], cur_x_q};
	assign dy = {rdata.y[31], rdata.y} - {cur_y_q[31], cur_y_q};
	assign sq_dist = {1'b0, sx_s3} + {1'b0, sy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (scan_q == '0);
		first_s2 <= first_s1;
		mx_s2 <= dx[32] ? (~dx[31:0] + 32'd1) : dx[31:0];
		my_s2 <= dy[32] ? (~dy[31:0] + 32'd1) : dy[31:0];
		yaw_s2 <= rdata.yaw;
		first_s3 <= first_s2;
		sx_s3 <= 64'(mx_s2) * 64'(mx_s2);
		sy_s3 <= 64'(my_s2) * 64'(my_s2);
		yaw_s3 <= yaw_s2;
		if (v_s3 && (first_s3 || sq_dist < best_q)) begin
			best_q <= sq_dist;
			best_yaw_q <= yaw_s3;
		end
	end

	assign diff = end_yaw_q - best_yaw_q;
	assign ang_c = diff[15] ? (~diff + 16'd1) : diff;
	assign th_sum = {1'b0, p2_q} + TH_ROUND;
	assign vc_sum = {1'b0, vp_q} + VC_ROUND;
	assign vcost = big_q ? BIG_COST : vc_sum[39:8];
	assign total = {5'd0, th_sum[63:36]} + {1'b0, vcost};

	always_ff @(posedge clk) begin
		case (state_q)
			S_ANG: begin
				ang_q <= ang_c;
				big_q <= (ang_c >= ANGLE_PI_4);
			end
			S_MUL1: p1_q <= 32'(ori_gain_q) * 32'(ang_q);
			S_MUL2: p2_q <= 63'(p1_q) * 63'(PI_Q29);
			S_WAIT: sf_q <= (speed < 32'(limit_q)) ? (limit_q - speed[22:0]) : '0;
			S_VMUL: vp_q <= 39'(vel_gain_q) * 39'(sf_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			scan_q <= '0;
			end_yaw_q <= '0;
			done_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.func == FUNC_LOAD) begin
							count_q <= room ? cnt_eff + CW'(1) : cnt_eff;
						end else if (req.traj_empty) begin
							done_q <= 1'b1;
							rsp_q <= '{status: STAT_EMPTY, cost: '0};
						end else if (count_q == '0) begin
							done_q <= 1'b1;
							rsp_q <= '{status: STAT_NO_GOAL, cost: '0};
						end else begin
							scan_q <= '0;
							end_yaw_q <= req.end_yaw;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + CW'(1);
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_ANG;
					end
				end
				S_ANG: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_WAIT;
				S_WAIT: begin
					if (spd_done) begin
						state_q <= S_VMUL;
					end
				end
				S_VMUL: state_q <= S_FIN;
				S_FIN: begin
					done_q <= 1'b1;
					rsp_q <= '{status: STAT_SCORED,
						cost: total[32] ? 32'hFFFF_FFFF : total[31:0]};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/ngh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ngh_ram #(
	parameter int W = 8,
	parameter int D = 64,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/ngh_speed.sv =====
// Translational speed unit: squares, sums and takes an iterative square root,
// two radicand bits per cycle. Depends on nothing but its ports.
`timescale 1ns / 1ps
module ngh_speed (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] vx,
	input  logic [31:0] vy,
	output logic        done,
	output logic [31:0] speed
);
	typedef enum logic [1:0] {SP_IDLE, SP_MUL, SP_SUM, SP_ITER} sp_state_t;

	sp_state_t   state_q;
	logic        done_q;
	logic [31:0] vx_q, vy_q;
	logic [63:0] sx_q, sy_q, n_q, res_q, bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SP_IDLE;
			done_q <= 1'b0;
		end else begin
			case (state_q)
				SP_IDLE: begin
					if (start) begin
						done_q <= 1'b0;
						state_q <= SP_MUL;
					end
				end
				SP_MUL: state_q <= SP_SUM;
				SP_SUM: state_q <= SP_ITER;
				SP_ITER: begin
					if (bit_q[0]) begin
						done_q <= 1'b1;
						state_q <= SP_IDLE;
					end
				end
				default: state_q <= SP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SP_IDLE: begin
				vx_q <= vx;
				vy_q <= vy;
			end
			SP_MUL: begin
				sx_q <= 64'(vx_q) * 64'(vx_q);
				sy_q <= 64'(vy_q) * 64'(vy_q);
			end
			SP_SUM: begin
				n_q <= sx_q + sy_q;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			SP_ITER: begin
				if (n_q >= trial) begin
					n_q <= n_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign speed = res_q[31:0];
endmodule

// ===== rtl/core/ngh_chk.sv =====
// Port-level checker for the nearest-goal heading cost block, bound to the top.
// Depends on ngh_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ngh_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input ngh_pkg::req_t req,
	input logic          done,
	input ngh_pkg::rsp_t rsp
);
	import ngh_pkg::*;

	`ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")
	`ASSERT_SAME(a_zero_cost, done && (rsp.status != STAT_SCORED), rsp.cost == '0, "nonzero cost on special status")
	`ASSERT_NEXT(a_load_silent, start && !busy && (req.func == FUNC_LOAD), !done, "load produced a result")
	`ASSERT_NEXT(a_empty_fast, start && !busy && (req.func == FUNC_SCORE) && req.traj_empty, done && (rsp.status == STAT_EMPTY), "empty trajectory not reported")
endmodule

bind nearest_goal_heading_cost_top ngh_chk u_ngh_chk (.*);

// ===== verif/tb_nearest_goal_heading_cost_top.sv =====
// Testbench for nearest_goal_heading_cost_top: random and directed goal loads and scores,
// checked against a cost predictor held in a small scoreboard class.
// Depends on ngh_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb_nearest_goal_heading_cost_top;
	import ngh_pkg::*;

	localparam int NGOALS = MAX_GOALS_DEF;
	localparam longint LIMIT = 2000000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	class cost_board;
		logic signed [31:0] cur_x, cur_y;
		logic [15:0] ori_gain, vel_gain;
		logic [22:0] spd_lim;
		logic [31:0] gx [NGOALS];
		logic [31:0] gy [NGOALS];
		logic [15:0] gyaw [NGOALS];
		int n_goals;
		rsp_t pending [$];
		int errors;

		function void clear();
			cur_x = 0;
			cur_y = 0;
			ori_gain = ORI_GAIN_RST;
			vel_gain = VEL_GAIN_RST;
			spd_lim = SPEED_LIMIT_RST;
			n_goals = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
			case (idx)
				CFG_CUR_X: cur_x = d;
				CFG_CUR_Y: cur_y = d;
				CFG_ORI_GAIN: ori_gain = d[15:0];
				CFG_VEL_GAIN: vel_gain = d[15:0];
				CFG_SPEED_LIMIT: spd_lim = d[22:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] root(logic [63:0] n);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n = n - res - b;
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			logic [64:0] d, bestd;
			logic [63:0] dx, dy, vx, vy, spd, sf;
			logic [15:0] ang;
			logic [95:0] th;
			logic [63:0] vc;
			logic [64:0] tot;
			int bi;
			if (r.func == FUNC_LOAD) begin
				if (r.first) n_goals = 0;
				if (n_goals < NGOALS) begin
					gx[n_goals] = r.goal_x;
					gy[n_goals] = r.goal_y;
					gyaw[n_goals] = r.goal_yaw;
					n_goals++;
				end
				return;
			end
			e.cost = 0;
			if (r.traj_empty) begin
				e.status = STAT_EMPTY;
			end else if (n_goals == 0) begin
				e.status = STAT_NO_GOAL;
			end else begin
				bi = 0;
				bestd = 0;
				for (int i = 0; i < n_goals; i++) begin
					dx = $signed(gx[i]) - 64'(cur_x);
					dy = $signed(gy[i]) - 64'(cur_y);
					if (dx[63]) dx = -dx;
					if (dy[63]) dy = -dy;
					d = 65'(dx * dx) + 65'(dy * dy);
					if (i == 0 || d < bestd) begin
						bi = i;
						bestd = d;
					end
				end
				ang = r.end_yaw - gyaw[bi];
				if (ang[15]) ang = 16'h0 - ang;
				th = (96'(ori_gain) * 96'(ang) * 96'(PI_Q29) + 96'(TH_ROUND)) >> 36;
				if (ang[15] || ang >= ANGLE_PI_4) begin
					vc = BIG_COST;
				end else begin
					vx = 64'(r.vel_x);
					vy = 64'(r.vel_y);
					if (vx[63]) vx = -vx;
					if (vy[63]) vy = -vy;
					spd = root(vx * vx + vy * vy);
					sf = spd < 64'(spd_lim) ? 64'(spd_lim) - spd : 0;
					vc = (64'(vel_gain) * sf + 64'd128) >> 8;
				end
				tot = 65'(th) + 65'(vc);
				e.status = STAT_SCORED;
				e.cost = tot > 65'hFFFF_FFFF ? 32'hFFFF_FFFF : tot[31:0];
			end
			pending.push_back(e);
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("result with no request pending: status %0d cost %0h", a.status, a.cost);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d actual %0d", e.status, a.status);
				errors++;
			end
			if (a.cost !== e.cost) begin
				$error("cost: expected %0h actual %0h", e.cost, a.cost);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, cfg_ready;
	req_t req = '0;
	rsp_t rsp;
	logic cfg_valid = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	cost_board board = new();
	int idle_pct = 0;
	longint cycles = 0;

	always #2 clk = ~clk;

	nearest_goal_heading_cost_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n && done) board.check_result(rsp);
		cycles++;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send(req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		req <= r;
		do @(posedge clk); while (busy);
		board.note_request(r);
	endtask

	task automatic drain();
		start <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, d);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic req_t rand_req();
		req_t r;
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = bits[$bits(req_t)-1:0];
		return r;
	endfunction

	function automatic req_t load_req(logic fst, logic [31:0] x, logic [31:0] y,
			logic [15:0] yaw);
		req_t r;
		r = rand_req();
		r.func = FUNC_LOAD;
		r.first = fst;
		r.goal_x = x;
		r.goal_y = y;
		r.goal_yaw = yaw;
		return r;
	endfunction

	function automatic req_t score_req(logic [15:0] yaw, logic [31:0] vx, logic [31:0] vy);
		req_t r;
		r = rand_req();
		r.func = FUNC_SCORE;
		r.traj_empty = 0;
		r.end_yaw = yaw;
		r.vel_x = vx;
		r.vel_y = vy;
		return r;
	endfunction

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(131072) - 65536;
			default: return $signed($urandom_range(4096)) - 2048;
		endcase
	endfunction

	initial begin
		req_t r;
		int nl;
		board.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, empty trajectory, extremes
		r = score_req(16'h0000, 32'h0, 32'h0);
		send(r);
		r.traj_empty = 1;
		send(r);
		send(load_req(1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000));
		send(load_req(0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF));
		send(load_req(0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000));
		send(score_req(16'h0000, 32'h8000_0000, 32'h8000_0000));
		send(score_req(16'h7FFF, 32'h7FFF_FFFF, 32'h0));
		send(score_req(16'h8000, 32'h0, 32'h0));
		send(score_req(16'h2000, 32'h0, 32'h0));
		send(score_req(16'hA000, 32'h0, 32'h0));
		send(score_req(16'h9FFF, 32'hFFFF_0000, 32'h0));
		r = score_req(16'h0000, 32'h0, 32'h0);
		r.first = 1;
		send(r);
		send(load_req(1, 32'h0, 32'h0, 16'h0));
		send(score_req(16'h1FFF, 32'h0, 32'd65536));
		send(score_req(16'h0001, 32'h0000_8000, 32'h0));
		for (int i = 0; i < 66; i++)
			send(load_req(i == 0, 32'(i * 7), 32'(-i), 16'(i * 300)));
		send(score_req(16'h0100, 32'h0, 32'h0));
		drain();

		write_reg(CFG_ORI_GAIN, 32'h0000_FFFF);
		write_reg(CFG_VEL_GAIN, 32'h0000_FFFF);
		write_reg(CFG_SPEED_LIMIT, 32'd4194304);
		write_reg(CFG_CUR_X, 32'h7FFF_FFFF);
		write_reg(CFG_CUR_Y, 32'h8000_0000);
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		send(score_req(16'h8000, 32'h0, 32'h0));
		send(score_req(16'h0000, 32'h0, 32'h0));

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 72;
				2: idle_pct = 9;
				default: idle_pct = 0;
			endcase
			drain();
			for (int k = 0; k < 5; k++) begin
				case ($urandom_range(3))
					0: write_reg(CFG_IDX_W'(k), 32'h0);
					1: write_reg(CFG_IDX_W'(k), 32'hFFFF_FFFF);
					default: write_reg(CFG_IDX_W'(k),
						k < 2 ? $urandom_range(2000000) - 1000000
						: $urandom_range(k == 4 ? 4194304 : 2048));
				endcase
			end
			for (int n = 0; n < 200; n++) begin
				if (n % 40 == 0) begin
					nl = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(8);
					for (int g = 0; g < nl; g++)
						send(load_req(g == 0, $urandom_range(3) == 0 ? $urandom
							: $urandom_range(400000) - 200000,
							$urandom_range(3) == 0 ? $urandom
							: $urandom_range(400000) - 200000, 16'($urandom)));
				end
				if ($urandom_range(19) == 0) begin
					send(rand_req());
				end else begin
					r = score_req(16'($urandom_range(1) ? $urandom
						: $urandom_range(20000) - 10000), rand_vel(), rand_vel());
					r.traj_empty = ($urandom_range(15) == 0);
					send(r);
				end
			end
		end

		drain();
		if (board.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
